// ===== design/irptm_pkg.sv =====
// Shared types, register indexes and reset constants of the IR pulse train modulator.
`default_nettype none
package irptm_pkg;

	localparam int CFG_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int UNIT_TICK_BITS = 16;
	localparam int IN_DUR_BITS    = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CARRIER_PERIOD  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CARRIER_HIGH    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TICKS_PER_UNIT  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_END_BURST_UNITS = 2'd3;

	localparam logic [CFG_BITS-1:0] RST_CARRIER_PERIOD  = 16'h0294;
	localparam logic [CFG_BITS-1:0] RST_CARRIER_HIGH    = 16'h014A;
	localparam logic [CFG_BITS-1:0] RST_TICKS_PER_UNIT  = 16'd49;
	localparam logic [CFG_BITS-1:0] RST_END_BURST_UNITS = 16'd560;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	typedef struct packed {
		logic                   mode;
		logic [IN_DUR_BITS-1:0] duration;
		logic                   last;
	} in_item_t;

	typedef struct packed {
		logic ir_out;
		logic mark_active;
		logic ready_res;
		logic frame_done;
		logic rejected;
	} out_item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] carrier_period;
		logic [CFG_BITS-1:0] carrier_high;
		logic [CFG_BITS-1:0] ticks_per_unit;
		logic [CFG_BITS-1:0] end_burst_units;
	} cfg_t;

endpackage
`default_nettype wire

// ===== design/irptm_in_stage.sv =====
// Input register stage holding one accepted word until the engine takes it.
`default_nettype none
module irptm_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  irptm_pkg::in_item_t in_data,
	input  wire                 take,
	output logic                valid_s1,
	output irptm_pkg::in_item_t item_s1
);

	// A held word leaves when the engine takes it, so a new one can enter the same cycle.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== design/irptm_engine.sv =====
// Transmitter state and the single-pass next-state and result logic for one word.
`default_nettype none
module irptm_engine #(
	parameter int DURATION_BITS = 16,
	parameter int CARRIER_BITS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  irptm_pkg::in_item_t  item,
	input  irptm_pkg::cfg_t      cfg,
	output irptm_pkg::out_item_t result
);

	localparam int CW = ((CARRIER_BITS > irptm_pkg::CFG_BITS) ?
		CARRIER_BITS : irptm_pkg::CFG_BITS) + 1;
	localparam int UTB = irptm_pkg::UNIT_TICK_BITS;

	logic                     phase_q, busy_q, ieb_q, lp_q;
	logic [DURATION_BITS-1:0] units_q;
	logic [UTB-1:0]           ut_q;
	logic [CARRIER_BITS-1:0]  cc_q;

	logic                     n_phase, n_busy, n_ieb, n_lp;
	logic [DURATION_BITS-1:0] n_units;
	logic [UTB-1:0]           n_ut;
	logic [CARRIER_BITS-1:0]  n_cc;

	logic [DURATION_BITS-1:0] dur_in, ebu, units_dec;
	logic [UTB-1:0]           ut_inc;
	logic [CW-1:0]            cc_inc, period_ext, high_ext;
	logic                     seg_end, ir, mark, done, rej;

	assign dur_in     = DURATION_BITS'(item.duration);
	assign ebu        = DURATION_BITS'(cfg.end_burst_units);
	assign units_dec  = units_q - DURATION_BITS'(1);
	assign ut_inc     = ut_q + UTB'(1);
	assign cc_inc     = CW'(cc_q) + CW'(1);
	assign period_ext = CW'(cfg.carrier_period);
	assign high_ext   = CW'(cfg.carrier_high);

	always_comb begin
		n_phase = phase_q;
		n_busy  = busy_q;
		n_ieb   = ieb_q;
		n_lp    = lp_q;
		n_units = units_q;
		n_ut    = ut_q;
		n_cc    = cc_q;
		seg_end = 1'b0;
		ir      = 1'b0;
		mark    = 1'b0;
		done    = 1'b0;
		rej     = 1'b0;

		if (item.mode == irptm_pkg::MODE_LOAD) begin
			if (busy_q) begin
				rej = 1'b1;
			end else begin
				n_phase = !phase_q;
				n_busy  = 1'b1;
				n_ieb   = 1'b0;
				n_lp    = item.last;
				n_units = dur_in;
				n_ut    = '0;
				if (!phase_q) begin
					n_cc = '0;
				end
				seg_end = (dur_in == '0);
			end
		end else if (busy_q) begin
			if (phase_q) begin
				mark = 1'b1;
				ir   = (CW'(cc_q) < high_ext);
				n_cc = (cc_inc >= period_ext) ? '0 : cc_inc[CARRIER_BITS-1:0];
			end
			if (ut_inc >= cfg.ticks_per_unit) begin
				n_ut    = '0;
				n_units = units_dec;
				seg_end = (units_dec == '0);
			end else begin
				n_ut = ut_inc;
			end
		end

		// Segment ran out: close the frame, start the end burst, or go idle.
		if (seg_end) begin
			if (n_ieb) begin
				done = 1'b1;
			end else if (n_lp) begin
				n_lp    = 1'b0;
				n_ieb   = 1'b1;
				n_busy  = 1'b1;
				n_phase = 1'b1;
				n_units = ebu;
				n_ut    = '0;
				n_cc    = '0;
				done    = (ebu == '0);
			end else begin
				n_busy = 1'b0;
			end
			if (done) begin
				n_busy  = 1'b0;
				n_ieb   = 1'b0;
				n_lp    = 1'b0;
				n_phase = 1'b0;
				n_units = '0;
				n_ut    = '0;
				n_cc    = '0;
			end
		end

		// A load reports the level the next tick will drive.
		if (item.mode == irptm_pkg::MODE_LOAD && n_busy && n_phase) begin
			mark = 1'b1;
			ir   = (CW'(n_cc) < high_ext);
		end

		result.ir_out      = ir;
		result.mark_active = mark;
		result.ready_res   = !n_busy;
		result.frame_done  = done;
		result.rejected    = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			busy_q  <= 1'b0;
			ieb_q   <= 1'b0;
			lp_q    <= 1'b0;
			units_q <= '0;
			ut_q    <= '0;
			cc_q    <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			busy_q  <= n_busy;
			ieb_q   <= n_ieb;
			lp_q    <= n_lp;
			units_q <= n_units;
			ut_q    <= n_ut;
			cc_q    <= n_cc;
		end
	end

endmodule
`default_nettype wire

// ===== design/irptm_out_stage.sv =====
// Output register holding one result word until the receiver takes it.
`default_nettype none
module irptm_out_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load_valid,
	input  irptm_pkg::out_item_t load_data,
	output logic                 can_load,
	output logic                 out_valid,
	input  wire                  out_ready,
	output irptm_pkg::out_item_t out_data
);

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) begin
			out_data <= load_data;
		end
	end

endmodule
`default_nettype wire

// ===== design/ir_pulse_train_modulator_core.sv =====
// Top level of the IR pulse train modulator: configuration registers and the word pipeline.
// Usage:
// Each input word is either a tick (mode 0), which advances the carrier and unit
// counters by one time step, or a load (mode 1), which starts the next segment of a
// frame with the given duration in units. The first segment of a frame is a carrier
// mark, and later segments alternate space and mark; after the segment flagged last,
// a closing mark burst is sent and frame_done pulses. A load while a segment runs is
// dropped and flagged as rejected. Every input word yields exactly one result word.
// There are two register stages: accepting a word loads the input register, and the
// engine result moves on into the output register when it can load, and the result
// word is offered from there. Throughput is one word per cycle while out_ready is high,
// set by the single engine pass between those two registers; the input side keeps
// accepting while a result waits as long as the output register can drain.
// When the receiver stalls, the output register holds its word, the input register
// fills, and in_ready falls until out_ready returns. Reset clears all state, empties
// both registers and restores the configuration registers to their default values.
// Configuration is written with cfg_we, cfg_index and cfg_wdata while no word is in flight.
`default_nettype none
module ir_pulse_train_modulator_core #(
	parameter int DURATION_BITS = 16,
	parameter int CARRIER_BITS  = 16
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        in_valid,
	output logic                                       in_ready,
	input  irptm_pkg::in_item_t                        in_data,
	output logic                                       out_valid,
	input  wire                                        out_ready,
	output irptm_pkg::out_item_t                       out_data,
	input  wire                                        cfg_we,
	input  wire  [irptm_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  wire  [irptm_pkg::CFG_BITS-1:0]             cfg_wdata
);

	irptm_pkg::cfg_t      cfg_q;
	irptm_pkg::in_item_t  item_s1;
	irptm_pkg::out_item_t result;
	logic                 valid_s1;
	logic                 can_load;
	logic                 step;

	// Configuration registers, written in place with no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_period  <= irptm_pkg::RST_CARRIER_PERIOD;
			cfg_q.carrier_high    <= irptm_pkg::RST_CARRIER_HIGH;
			cfg_q.ticks_per_unit  <= irptm_pkg::RST_TICKS_PER_UNIT;
			cfg_q.end_burst_units <= irptm_pkg::RST_END_BURST_UNITS;
		end else if (cfg_we) begin
			case (cfg_index)
				irptm_pkg::REG_CARRIER_PERIOD:  cfg_q.carrier_period  <= cfg_wdata;
				irptm_pkg::REG_CARRIER_HIGH:    cfg_q.carrier_high    <= cfg_wdata;
				irptm_pkg::REG_TICKS_PER_UNIT:  cfg_q.ticks_per_unit  <= cfg_wdata;
				irptm_pkg::REG_END_BURST_UNITS: cfg_q.end_burst_units <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The engine advances exactly when the held word moves into the output register.
	assign step = valid_s1 && can_load;

	irptm_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.take     (can_load),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	irptm_engine #(
		.DURATION_BITS (DURATION_BITS),
		.CARRIER_BITS  (CARRIER_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	irptm_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_data  (result),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	// A finished frame always leaves the line idle and ready for a new load.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.ready_res)
		else $error("frame_done without ready_res");

	// A rejected load means a segment was running and still is.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.rejected |-> !out_data.ready_res)
		else $error("rejected load reported as ready");

	// The pin only carries carrier during a mark.
	a_ir_in_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ir_out |-> out_data.mark_active)
		else $error("ir_out high outside a mark");

	// An accepted word is held in the input register on the next cycle.
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost");
`endif

endmodule
`default_nettype wire
